/* sv/chi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// shared constants, codes and types of the cubic hermite interpolator
// no dependencies; used by every other file of the block

package chi_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int ADDR_W       = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int DATA_W       = 32;
    localparam int FRAC_W       = 16;
    localparam int SEG_W        = 9;
    localparam int INTERVAL_W   = 8;
    localparam int CFG_IDX_W    = 2;

    // t spans -8.0 .. +8.0 grid steps
    localparam int T_W  = FRAC_W + 5;
    localparam int D_W  = DATA_W + 4;
    localparam int C_W  = DATA_W + 6;
    localparam int A1_W = C_W + 6;
    localparam int A2_W = A1_W + 4;
    localparam int A3_W = A2_W + 4;
    localparam int P1_W = C_W + T_W;
    localparam int P2_W = A1_W + T_W;
    localparam int P3_W = A2_W + T_W;

    localparam logic [T_W-1:0] T_LIMIT = T_W'(8 << FRAC_W);

    localparam logic signed [A3_W-1:0] SAT_MAX =
        {{(A3_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [A3_W-1:0] SAT_MIN =
        {{(A3_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_GRID_START = 2'd0,
        CFG_INV_STEP   = 2'd1,
        CFG_SEG_COUNT  = 2'd2
    } cfg_idx_t;

    typedef struct packed
    {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_seg;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } chi_store_req_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] ym1;
        logic [DATA_W-1:0] y0;
        logic [DATA_W-1:0] yp1;
        logic [DATA_W-1:0] yp2;
    } chi_store_rsp_t;

endpackage

`default_nettype wire

/* sv/chi_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channels of the interpolator: request words and result words
// widths follow chi_pkg

interface chi_item_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [chi_pkg::SEG_W-1:0]           sample_index;
    logic signed [chi_pkg::DATA_W-1:0]   sample_value;
    logic signed [chi_pkg::DATA_W-1:0]   query_x;

    modport source (output valid, operation, sample_index, sample_value, query_x,
                    input ready);
    modport sink   (input valid, operation, sample_index, sample_value, query_x,
                    output ready);
endinterface

interface chi_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [chi_pkg::DATA_W-1:0]   value;
    logic                                saturated;
    logic [chi_pkg::INTERVAL_W-1:0]      interval;

    modport source (output valid, value, saturated, interval, input ready);
    modport sink   (input valid, value, saturated, interval, output ready);
endinterface

`default_nettype wire

/* sv/chi_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// sample store: four copies, each one write and one registered read per cycle
// reads the four samples around a segment; depends on chi_pkg

module chi_store
(
    input  logic                    clk,
    input  chi_pkg::chi_store_req_t req,
    output chi_pkg::chi_store_rsp_t rsp
);

    logic [chi_pkg::DATA_W-1:0] mem_m1 [chi_pkg::MAX_SEGMENTS+1];
    logic [chi_pkg::DATA_W-1:0] mem_0  [chi_pkg::MAX_SEGMENTS+1];
    logic [chi_pkg::DATA_W-1:0] mem_p1 [chi_pkg::MAX_SEGMENTS+1];
    logic [chi_pkg::DATA_W-1:0] mem_p2 [chi_pkg::MAX_SEGMENTS+1];

    logic [chi_pkg::ADDR_W:0]   base;
    logic [chi_pkg::ADDR_W:0]   plus2;
    logic [chi_pkg::ADDR_W-1:0] addr_m1;
    logic [chi_pkg::ADDR_W-1:0] addr_0;
    logic [chi_pkg::ADDR_W-1:0] addr_p1;
    logic [chi_pkg::ADDR_W-1:0] addr_p2;
    chi_pkg::chi_store_rsp_t    rsp_reg;

    always_comb
    begin
        base    = (chi_pkg::ADDR_W + 1)'(req.rd_seg);
        plus2   = base + (chi_pkg::ADDR_W + 1)'(2);
        // neighbors off the ends are read but never used
        addr_m1 = (base == '0) ? '0 : chi_pkg::ADDR_W'(base - 1'b1);
        addr_0  = chi_pkg::ADDR_W'(base);
        addr_p1 = chi_pkg::ADDR_W'(base + 1'b1);
        addr_p2 = (plus2 > (chi_pkg::ADDR_W + 1)'(chi_pkg::MAX_SEGMENTS)) ?
                  chi_pkg::ADDR_W'(chi_pkg::MAX_SEGMENTS) : chi_pkg::ADDR_W'(plus2);
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_m1[req.wr_addr] <= req.wr_data;
            mem_0[req.wr_addr]  <= req.wr_data;
            mem_p1[req.wr_addr] <= req.wr_data;
            mem_p2[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rsp_reg.ym1 <= mem_m1[addr_m1];
            rsp_reg.y0  <= mem_0[addr_0];
            rsp_reg.yp1 <= mem_p1[addr_p1];
            rsp_reg.yp2 <= mem_p2[addr_p2];
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

/* sv/cubic_hermite_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none
// cubic hermite interpolator on a uniform q16.16 grid
// an accepted eval word passes registers s1 to s12 and the output register to its result word
// throughput: one word per cycle; a held result freezes the whole pipeline
// the three horner multiplies and the position multiply each own a stage
// reset clears valid bits and restores register defaults; samples are
// undefined until loaded. depends on chi_pkg, chi_if, chi_store

module cubic_hermite_interpolator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [chi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chi_pkg::DATA_W-1:0]      cfg_data,
    chi_item_if.sink                        item,
    chi_result_if.source                    result
);

    localparam int DW = chi_pkg::DATA_W;
    localparam int FW = chi_pkg::FRAC_W;
    localparam int TW = chi_pkg::T_W;
    localparam int IW = chi_pkg::IDX_W;
    localparam int AW = chi_pkg::ADDR_W;

    // configuration
    logic signed [DW-1:0]           grid_start_reg;
    logic [DW-1:0]                  inv_step_reg;
    logic [chi_pkg::SEG_W-1:0]      seg_count_reg;
    logic [AW-1:0]                  seg_n;
    logic [AW-1:0]                  seg_last_a;
    logic [IW-1:0]                  seg_last;

    logic adv;

    // stage registers
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    logic s7_v_reg, s8_v_reg, s9_v_reg, s10_v_reg, s11_v_reg, s12_v_reg, out_v_reg;

    chi_pkg::op_t                   s1_op_reg, s2_op_reg, s3_op_reg;
    logic [chi_pkg::SEG_W-1:0]      s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [DW-1:0]                  s1_val_reg, s2_val_reg, s3_val_reg;
    logic [DW-1:0]                  s1_mag_reg;
    logic                           s1_neg_reg, s2_neg_reg;
    logic [2*DW-1:0]                s2_prod_reg;

    logic [IW-1:0] s3_i_reg, s4_i_reg, s5_i_reg, s6_i_reg, s7_i_reg, s8_i_reg;
    logic [IW-1:0] s9_i_reg, s10_i_reg, s11_i_reg, s12_i_reg;
    logic signed [TW-1:0] s3_t_reg, s4_t_reg, s5_t_reg, s6_t_reg, s7_t_reg;
    logic signed [TW-1:0] s8_t_reg, s9_t_reg, s10_t_reg;
    logic s3_first_reg, s3_last_reg, s4_first_reg, s4_last_reg;

    logic signed [DW-1:0]           s5_a_reg, s6_a_reg, s7_a_reg, s8_a_reg;
    logic signed [DW-1:0]           s9_a_reg, s10_a_reg, s11_a_reg;
    logic signed [DW-1:0]           s5_b_reg;
    logic signed [chi_pkg::D_W-1:0] s5_di_reg, s5_dn_reg;
    logic signed [chi_pkg::D_W-1:0] s6_c1_reg, s7_c1_reg, s8_c1_reg, s9_c1_reg;
    logic signed [chi_pkg::C_W-1:0] s6_c3_reg, s6_c2_reg, s7_c2_reg;
    logic signed [chi_pkg::P1_W-1:0] s7_p1_reg;
    logic signed [chi_pkg::A1_W-1:0] s8_acc1_reg;
    logic signed [chi_pkg::P2_W-1:0] s9_p2_reg;
    logic signed [chi_pkg::A2_W-1:0] s10_acc2_reg;
    logic signed [chi_pkg::P3_W-1:0] s11_p3_reg;
    logic signed [chi_pkg::A3_W-1:0] s12_acc3_reg;

    logic signed [DW-1:0]             out_value_reg;
    logic                             out_sat_reg;
    logic [chi_pkg::INTERVAL_W-1:0]   out_interval_reg;

    // next values
    logic signed [DW:0]     diff_next;
    logic [DW:0]            diff_abs;
    logic [DW-1:0]          s1_mag_next;
    logic [2*DW-1:0]        s2_prod_next;
    logic [2*DW-FW:0]       pos_neg;
    logic [TW-1:0]          mag_neg;
    logic [DW-1:0]          whole;
    logic [2*DW-FW-1:0]     rem_pos;
    logic [IW-1:0]          s3_i_next;
    logic [TW-1:0]          s3_t_next;

    chi_pkg::chi_store_req_t store_req;
    chi_pkg::chi_store_rsp_t store_rsp;

    logic signed [chi_pkg::D_W-1:0] ym1_e, y0_e, yp1_e, yp2_e;
    logic signed [chi_pkg::D_W-1:0] s5_di_next, s5_dn_next;
    logic signed [chi_pkg::C_W-1:0] a_c, b_c, di_c, dn_c, s6_c3_next, s6_c2_next;
    logic signed [chi_pkg::P1_W-1:0] p1_sh;
    logic signed [chi_pkg::P2_W-1:0] p2_sh;
    logic signed [chi_pkg::P3_W-1:0] p3_sh;
    logic signed [chi_pkg::A3_W-1:0] res_full;
    logic signed [DW-1:0]            out_value_next;
    logic                            out_sat_next;

    assign adv        = !out_v_reg || result.ready;
    assign item.ready = adv;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_start_reg <= '0;
            inv_step_reg   <= DW'(32'd65536);
            seg_count_reg  <= chi_pkg::SEG_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                chi_pkg::CFG_GRID_START: grid_start_reg <= cfg_data;
                chi_pkg::CFG_INV_STEP:   inv_step_reg   <= cfg_data;
                chi_pkg::CFG_SEG_COUNT:  seg_count_reg  <= cfg_data[chi_pkg::SEG_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        priority if (seg_count_reg < chi_pkg::SEG_W'(2))
            seg_n = AW'(2);
        else if (AW'(seg_count_reg) > AW'(chi_pkg::MAX_SEGMENTS)
                 || (chi_pkg::SEG_W > AW && seg_count_reg >
                     chi_pkg::SEG_W'(chi_pkg::MAX_SEGMENTS)))
            seg_n = AW'(chi_pkg::MAX_SEGMENTS);
        else
            seg_n = AW'(seg_count_reg);
        seg_last_a = seg_n - 1'b1;
        seg_last   = IW'(seg_last_a);
    end

    // stage 1: distance from the grid origin
    always_comb
    begin
        diff_next   = $signed({item.query_x[DW-1], item.query_x})
                    - $signed({grid_start_reg[DW-1], grid_start_reg});
        diff_abs    = diff_next[DW] ? ((DW + 1)'(0) - diff_next) : diff_next;
        s1_mag_next = diff_abs[DW-1:0];
    end

    // stage 2: scale by the inverse step
    assign s2_prod_next = s1_mag_reg * inv_step_reg;

    // stage 3: segment and fraction
    always_comb
    begin
        pos_neg = (2*DW - FW + 1)'(s2_prod_reg[2*DW-1:FW])
                + (2*DW - FW + 1)'(|s2_prod_reg[FW-1:0]);
        mag_neg = (pos_neg > (2*DW - FW + 1)'(chi_pkg::T_LIMIT)) ?
                  chi_pkg::T_LIMIT : pos_neg[TW-1:0];
        whole   = s2_prod_reg[2*DW-1:2*FW];
        rem_pos = s2_prod_reg[2*DW-1:FW] - ((2*DW - FW)'(seg_last) << FW);
        if (s2_neg_reg)
        begin
            s3_i_next = '0;
            s3_t_next = TW'(0) - mag_neg;
        end
        else if (whole > DW'(seg_last))
        begin
            // beyond the last segment: extrapolate with the end cubic
            s3_i_next = seg_last;
            s3_t_next = (rem_pos > (2*DW - FW)'(chi_pkg::T_LIMIT)) ?
                        chi_pkg::T_LIMIT : rem_pos[TW-1:0];
        end
        else
        begin
            s3_i_next = whole[IW-1:0];
            s3_t_next = TW'(s2_prod_reg[2*FW-1:FW]);
        end
    end

    // stage 4: sample reads, loads write in the same stage
    always_comb
    begin
        store_req.rd_en   = adv;
        store_req.rd_seg  = s3_i_reg;
        store_req.wr_en   = adv && s3_v_reg && (s3_op_reg == chi_pkg::OP_LOAD)
                         && (s3_idx_reg <= chi_pkg::SEG_W'(chi_pkg::MAX_SEGMENTS));
        store_req.wr_addr = AW'(s3_idx_reg);
        store_req.wr_data = s3_val_reg;
    end

    chi_store u_store
    (
        .clk (clk),
        .req (store_req),
        .rsp (store_rsp)
    );

    // stage 5: end slopes, twice slope times step
    always_comb
    begin
        ym1_e = chi_pkg::D_W'($signed(store_rsp.ym1));
        y0_e  = chi_pkg::D_W'($signed(store_rsp.y0));
        yp1_e = chi_pkg::D_W'($signed(store_rsp.yp1));
        yp2_e = chi_pkg::D_W'($signed(store_rsp.yp2));
        if (s4_first_reg)
            s5_di_next = (yp1_e <<< 2) - yp2_e - (y0_e <<< 1) - y0_e;
        else
            s5_di_next = yp1_e - ym1_e;
        if (s4_last_reg)
            s5_dn_next = (yp1_e <<< 1) + yp1_e + ym1_e - (y0_e <<< 2);
        else
            s5_dn_next = yp2_e - y0_e;
    end

    // stage 6: polynomial coefficients
    always_comb
    begin
        a_c        = chi_pkg::C_W'(s5_a_reg);
        b_c        = chi_pkg::C_W'(s5_b_reg);
        di_c       = chi_pkg::C_W'(s5_di_reg);
        dn_c       = chi_pkg::C_W'(s5_dn_reg);
        s6_c3_next = ((a_c - b_c) <<< 2) + di_c + dn_c;
        s6_c2_next = ((b_c - a_c) <<< 2) + ((b_c - a_c) <<< 1) - (di_c <<< 1) - dn_c;
    end

    // horner steps, floor of the q16 product is an arithmetic shift; the halved sum saturates
    always_comb
    begin
        p1_sh    = s7_p1_reg >>> FW;
        p2_sh    = s9_p2_reg >>> FW;
        p3_sh    = s11_p3_reg >>> FW;
        res_full = s12_acc3_reg >>> 1;
        priority if (res_full > chi_pkg::SAT_MAX)
        begin
            out_value_next = DW'(chi_pkg::SAT_MAX);
            out_sat_next   = 1'b1;
        end
        else if (res_full < chi_pkg::SAT_MIN)
        begin
            out_value_next = DW'(chi_pkg::SAT_MIN);
            out_sat_next   = 1'b1;
        end
        else
        begin
            out_value_next = DW'(res_full);
            out_sat_next   = 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
            s12_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= item.valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            // loads end at the store
            s4_v_reg  <= s3_v_reg && (s3_op_reg == chi_pkg::OP_EVAL);
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= s10_v_reg;
            s12_v_reg <= s11_v_reg;
            out_v_reg <= s12_v_reg;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg    <= chi_pkg::op_t'(item.operation);
            s1_idx_reg   <= item.sample_index;
            s1_val_reg   <= item.sample_value;
            s1_mag_reg   <= s1_mag_next;
            s1_neg_reg   <= diff_next[DW];

            s2_op_reg    <= s1_op_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_val_reg   <= s1_val_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_prod_reg  <= s2_prod_next;

            s3_op_reg    <= s2_op_reg;
            s3_idx_reg   <= s2_idx_reg;
            s3_val_reg   <= s2_val_reg;
            s3_i_reg     <= s3_i_next;
            s3_t_reg     <= s3_t_next;
            s3_first_reg <= (s3_i_next == '0);
            s3_last_reg  <= (s3_i_next == seg_last);

            s4_i_reg     <= s3_i_reg;
            s4_t_reg     <= s3_t_reg;
            s4_first_reg <= s3_first_reg;
            s4_last_reg  <= s3_last_reg;

            s5_i_reg     <= s4_i_reg;
            s5_t_reg     <= s4_t_reg;
            s5_a_reg     <= store_rsp.y0;
            s5_b_reg     <= store_rsp.yp1;
            s5_di_reg    <= s5_di_next;
            s5_dn_reg    <= s5_dn_next;

            s6_i_reg     <= s5_i_reg;
            s6_t_reg     <= s5_t_reg;
            s6_a_reg     <= s5_a_reg;
            s6_c3_reg    <= s6_c3_next;
            s6_c2_reg    <= s6_c2_next;
            s6_c1_reg    <= s5_di_reg;

            s7_i_reg     <= s6_i_reg;
            s7_t_reg     <= s6_t_reg;
            s7_a_reg     <= s6_a_reg;
            s7_c2_reg    <= s6_c2_reg;
            s7_c1_reg    <= s6_c1_reg;
            s7_p1_reg    <= s6_c3_reg * s6_t_reg;

            s8_i_reg     <= s7_i_reg;
            s8_t_reg     <= s7_t_reg;
            s8_a_reg     <= s7_a_reg;
            s8_c1_reg    <= s7_c1_reg;
            s8_acc1_reg  <= chi_pkg::A1_W'(p1_sh) + chi_pkg::A1_W'(s7_c2_reg);

            s9_i_reg     <= s8_i_reg;
            s9_t_reg     <= s8_t_reg;
            s9_a_reg     <= s8_a_reg;
            s9_c1_reg    <= s8_c1_reg;
            s9_p2_reg    <= s8_acc1_reg * s8_t_reg;

            s10_i_reg    <= s9_i_reg;
            s10_t_reg    <= s9_t_reg;
            s10_a_reg    <= s9_a_reg;
            s10_acc2_reg <= chi_pkg::A2_W'(p2_sh) + chi_pkg::A2_W'(s9_c1_reg);

            s11_i_reg    <= s10_i_reg;
            s11_a_reg    <= s10_a_reg;
            s11_p3_reg   <= s10_acc2_reg * s10_t_reg;

            s12_i_reg    <= s11_i_reg;
            s12_acc3_reg <= chi_pkg::A3_W'(p3_sh) + (chi_pkg::A3_W'(s11_a_reg) <<< 1);

            out_value_reg    <= out_value_next;
            out_sat_reg      <= out_sat_next;
            out_interval_reg <= chi_pkg::INTERVAL_W'(s12_i_reg);
        end
    end

    assign result.valid     = out_v_reg;
    assign result.value     = out_value_reg;
    assign result.saturated = out_sat_reg;
    assign result.interval  = out_interval_reg;

endmodule

`default_nettype wire

/* sv/chi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// port-level checks of the interpolator, bound to the top level
// depends on chi_pkg and cubic_hermite_interpolator

module chi_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [chi_pkg::DATA_W-1:0]   out_value,
    input logic                         out_saturated
);

    localparam logic [chi_pkg::DATA_W-1:0] VAL_MAX = {1'b0, {(chi_pkg::DATA_W-1){1'b1}}};
    localparam logic [chi_pkg::DATA_W-1:0] VAL_MIN = {1'b1, {(chi_pkg::DATA_W-1){1'b0}}};

    // held result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value))
        else $error("result value changed while stalled");

    // a stalled output holds off new input words
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // clipping flag only with a clipped value
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_saturated |-> (out_value == VAL_MAX || out_value == VAL_MIN))
        else $error("saturated flag without a limit value");

endmodule

bind cubic_hermite_interpolator chi_checker u_chi_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (item.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_value     (result.value),
    .out_saturated (result.saturated)
);

`default_nettype wire
